FILE: hw/rtl/number_to_text_formatter_core_assert.svh
// Assertion macros shared by the formatter RTL.
`ifndef NUMBER_TO_TEXT_FORMATTER_CORE_ASSERT_SVH
`define NUMBER_TO_TEXT_FORMATTER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define N2T_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("n2t assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define N2T_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("n2t assertion failed");

`endif

FILE: hw/rtl/n2t_pkg.sv
package n2t_pkg;

	localparam int DigDepth = 10;
	localparam int RomanDigits = 5;
	localparam logic [31:0] RomanLimit = 32'd40000;

	// Reciprocal constants, floor(2^s / d).
	localparam logic [31:0] Recip10 = 32'd3435973836;
	localparam logic [31:0] Recip26 = 32'd2643056797;

	localparam logic [2:0] FMT_DEC      = 3'd0;
	localparam logic [2:0] FMT_ROMAN_LO = 3'd1;
	localparam logic [2:0] FMT_ROMAN_UP = 3'd2;
	localparam logic [2:0] FMT_ALPHA_LO = 3'd3;
	localparam logic [2:0] FMT_ALPHA_UP = 3'd4;

	localparam logic CFG_FORMAT = 1'b0;
	localparam logic CFG_PAD    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ISSUE, ST_WAIT, ST_SIGN, ST_PAD, ST_BODY
	} state_t;

	typedef enum logic [1:0] {KIND_DEC, KIND_ROMAN, KIND_ALPHA} kind_t;

	typedef struct packed {
		logic go;
		logic sel26;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [4:0]  rem;
	} div_rsp_t;

	// Lower case Roman letters, largest first: z w m d c l x v i.
	function automatic logic [7:0] roman_set(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h7A;
			4'd1: c = 8'h77;
			4'd2: c = 8'h6D;
			4'd3: c = 8'h64;
			4'd4: c = 8'h63;
			4'd5: c = 8'h6C;
			4'd6: c = 8'h78;
			4'd7: c = 8'h76;
			default: c = 8'h69;
		endcase
		return c;
	endfunction

	// Number of letters one decimal digit turns into.
	function automatic logic [2:0] roman_len(input logic [4:0] d);
		logic [2:0] n;
		case (d)
			5'd9, 5'd4: n = 3'd2;
			5'd5, 5'd6, 5'd7, 5'd8: n = 3'(d - 5'd4);
			default: n = d[2:0];
		endcase
		return n;
	endfunction

	// Letter j of digit d at decimal place k (k = 4 is the ten-thousands).
	function automatic logic [7:0] roman_char(input logic [2:0] k, input logic [4:0] d,
		input logic [1:0] j);
		logic [3:0] one_i;
		logic [7:0] c;
		one_i = 4'd8 - {k, 1'b0};
		if (d == 5'd9)
			c = (j == 2'd0) ? roman_set(one_i) : roman_set(one_i - 4'd2);
		else if (d == 5'd4)
			c = (j == 2'd0) ? roman_set(one_i) : roman_set(one_i - 4'd1);
		else if (d >= 5'd5)
			c = (j == 2'd0) ? roman_set(one_i - 4'd1) : roman_set(one_i);
		else
			c = roman_set(one_i);
		return c;
	endfunction

endpackage

FILE: hw/rtl/n2t_divc.sv
// Divides by 10 or 26 with a reciprocal multiply and one correction step.
module n2t_divc (
	input  logic              clk,
	input  logic              arst_n,
	input  n2t_pkg::div_req_t req,
	input  logic [31:0]       dividend,
	output n2t_pkg::div_rsp_t rsp
);

	logic        v_s1, v_s2, v_s3;
	logic        sel_s1, sel_s2;
	logic [63:0] prod_s1;
	logic [31:0] q_s2, q_s3;
	logic [5:0]  n6_s1, r_s2;
	logic [4:0]  r_s3;
	logic [31:0] q_est;
	logic [5:0]  qd6;
	logic [5:0]  dlim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(dividend) * 64'(req.sel26 ? n2t_pkg::Recip26 : n2t_pkg::Recip10);
		n6_s1   <= dividend[5:0];
		sel_s1  <= req.sel26;
	end

	// The estimate is the true quotient or one less, so the remainder is below 52.
	always_comb begin
		q_est = sel_s1 ? {4'b0, prod_s1[63:36]} : {3'b0, prod_s1[63:35]};
		qd6 = sel_s1 ? 6'((q_est[5:0] << 4) + (q_est[5:0] << 3) + (q_est[5:0] << 1))
			: 6'((q_est[5:0] << 3) + (q_est[5:0] << 1));
		dlim = sel_s2 ? 6'd26 : 6'd10;
	end

	always_ff @(posedge clk) begin
		q_s2   <= q_est;
		r_s2   <= n6_s1 - qd6;
		sel_s2 <= sel_s1;
		if (r_s2 >= dlim) begin
			q_s3 <= q_s2 + 32'd1;
			r_s3 <= 5'(r_s2 - dlim);
		end else begin
			q_s3 <= q_s2;
			r_s3 <= r_s2[4:0];
		end
	end

	assign rsp.done = v_s3;
	assign rsp.quot = q_s3;
	assign rsp.rem  = r_s3;

endmodule

FILE: hw/rtl/number_to_text_formatter_core.sv
// Each digit or letter is found in turn in the shared divide unit (3-stage
// reciprocal multiply plus issue), up to 10 of them, and then the characters go out.
// Characters go out one per cycle, up to 64, but an empty pad slot or a Roman digit of zero
// leaves a gap. The sign and pad slots are passed through even when they are empty.
// busy stays high until the last character has been shown; start is ignored meanwhile.
// Reset clears the sequencer and sets both registers to 0 (plain decimal).
// The receiver cannot stall: each character is on the ports for exactly one cycle.
`include "number_to_text_formatter_core_assert.svh"

module number_to_text_formatter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] number_in,
	output logic        char_strobe,
	output logic [7:0]  char_code,
	output logic        last_char,
	output logic        roman_overflow,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);

	n2t_pkg::state_t    state_q, state_d;
	n2t_pkg::kind_t     kind_q;
	n2t_pkg::div_req_t  dreq;
	n2t_pkg::div_rsp_t  drsp;

	logic [2:0]  fmt_q;
	logic [5:0]  padw_q;
	logic        upper_q, neg_q, ovf_q;
	logic [5:0]  pad_q, padcnt_q;
	logic [31:0] cur_q;
	logic [3:0]  nd_q, pos_q;
	logic [1:0]  sub_q;
	logic [4:0]  dig_q [n2t_pkg::DigDepth];

	logic        strobe_q, last_q;
	logic [7:0]  code_q;

	logic        accept, emit, last_d;
	logic [7:0]  ch_d;
	logic [31:0] mag, next_cur;
	logic [4:0]  dval, dcur;
	logic [2:0]  rlen;
	logic        lower_nz, more;
	logic        is_roman, is_alpha;

	n2t_divc u_divc (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dreq),
		.dividend(cur_q),
		.rsp     (drsp)
	);

	assign accept   = start && !busy;
	assign mag      = number_in[31] ? (32'd0 - number_in) : number_in;
	assign is_roman = (fmt_q == n2t_pkg::FMT_ROMAN_LO) || (fmt_q == n2t_pkg::FMT_ROMAN_UP);
	assign is_alpha = (fmt_q == n2t_pkg::FMT_ALPHA_LO) || (fmt_q == n2t_pkg::FMT_ALPHA_UP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= n2t_pkg::FMT_DEC;
			padw_q <= 6'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				n2t_pkg::CFG_FORMAT: fmt_q <= cfg_data[2:0];
				n2t_pkg::CFG_PAD:    padw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= n2t_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		dval     = drsp.rem;
		next_cur = drsp.quot;
		if (kind_q == n2t_pkg::KIND_ALPHA && drsp.rem == 5'd0) begin
			dval     = 5'd26;
			next_cur = drsp.quot - 32'd1;
		end
		case (kind_q)
			n2t_pkg::KIND_ROMAN: more = (nd_q != 4'(n2t_pkg::RomanDigits - 1));
			n2t_pkg::KIND_ALPHA: more = (next_cur != 32'd0);
			default:             more = (drsp.quot != 32'd0);
		endcase
		dcur = dig_q[pos_q];
		rlen = n2t_pkg::roman_len(dcur);
		lower_nz = 1'b0;
		for (int i = 0; i < n2t_pkg::RomanDigits; i++)
			if (4'(i) < pos_q && dig_q[i] != 5'd0)
				lower_nz = 1'b1;
	end

	always_comb begin
		state_d  = state_q;
		dreq.go    = 1'b0;
		dreq.sel26 = (kind_q == n2t_pkg::KIND_ALPHA);
		emit     = 1'b0;
		last_d   = 1'b0;
		ch_d     = 8'h30;
		case (state_q)
			n2t_pkg::ST_IDLE: if (start) state_d = n2t_pkg::ST_ISSUE;
			n2t_pkg::ST_ISSUE: begin
				dreq.go = 1'b1;
				state_d = n2t_pkg::ST_WAIT;
			end
			n2t_pkg::ST_WAIT: if (drsp.done)
				state_d = more ? n2t_pkg::ST_ISSUE : n2t_pkg::ST_SIGN;
			n2t_pkg::ST_SIGN: begin
				emit    = neg_q;
				ch_d    = 8'h2D;
				state_d = n2t_pkg::ST_PAD;
			end
			n2t_pkg::ST_PAD: begin
				emit = (padcnt_q != 6'd0);
				if (padcnt_q <= 6'd1)
					state_d = n2t_pkg::ST_BODY;
			end
			n2t_pkg::ST_BODY: begin
				case (kind_q)
					n2t_pkg::KIND_ROMAN: begin
						emit   = (rlen != 3'd0);
						ch_d   = n2t_pkg::roman_char(pos_q[2:0], dcur, sub_q) -
							(upper_q ? 8'h20 : 8'h00);
						last_d = emit && (3'(sub_q) == rlen - 3'd1) && !lower_nz;
						if (last_d || (pos_q == 4'd0 && !emit))
							state_d = n2t_pkg::ST_IDLE;
					end
					n2t_pkg::KIND_ALPHA: begin
						emit   = 1'b1;
						ch_d   = (upper_q ? 8'h41 : 8'h61) + {3'b0, dcur} - 8'd1;
						last_d = (pos_q == 4'd0);
						if (last_d) state_d = n2t_pkg::ST_IDLE;
					end
					default: begin
						emit   = 1'b1;
						ch_d   = 8'h30 + {3'b0, dcur};
						last_d = (pos_q == 4'd0);
						if (last_d) state_d = n2t_pkg::ST_IDLE;
					end
				endcase
			end
			default: state_d = n2t_pkg::ST_IDLE;
		endcase
		if (state_q == n2t_pkg::ST_IDLE && busy)
			state_d = n2t_pkg::ST_IDLE;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= number_in[31];
			cur_q   <= mag;
			nd_q    <= 4'd0;
			upper_q <= (fmt_q == n2t_pkg::FMT_ROMAN_UP) || (fmt_q == n2t_pkg::FMT_ALPHA_UP);
			ovf_q   <= 1'b0;
			pad_q   <= 6'd0;
			if (mag == 32'd0) begin
				kind_q <= n2t_pkg::KIND_DEC;
				if (!is_roman && !is_alpha) pad_q <= padw_q;
			end else if (is_roman && mag >= n2t_pkg::RomanLimit) begin
				kind_q <= n2t_pkg::KIND_DEC;
				ovf_q  <= 1'b1;
			end else if (is_roman) begin
				kind_q <= n2t_pkg::KIND_ROMAN;
			end else if (is_alpha) begin
				kind_q <= n2t_pkg::KIND_ALPHA;
			end else begin
				kind_q <= n2t_pkg::KIND_DEC;
				pad_q  <= padw_q;
			end
		end
		if (state_q == n2t_pkg::ST_WAIT && drsp.done) begin
			dig_q[nd_q] <= dval;
			nd_q        <= nd_q + 4'd1;
			cur_q       <= next_cur;
		end
		if (state_q == n2t_pkg::ST_SIGN) begin
			padcnt_q <= (pad_q > 6'(nd_q)) ? pad_q - 6'(nd_q) : 6'd0;
			pos_q    <= (kind_q == n2t_pkg::KIND_ROMAN) ?
				4'(n2t_pkg::RomanDigits - 1) : nd_q - 4'd1;
			sub_q    <= 2'd0;
		end
		if (state_q == n2t_pkg::ST_PAD && padcnt_q != 6'd0)
			padcnt_q <= padcnt_q - 6'd1;
		if (state_q == n2t_pkg::ST_BODY) begin
			if (kind_q == n2t_pkg::KIND_ROMAN) begin
				if (!emit || 3'(sub_q) == rlen - 3'd1) begin
					sub_q <= 2'd0;
					pos_q <= pos_q - 4'd1;
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end else begin
				pos_q <= pos_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= emit;
			last_q   <= emit && last_d;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= ch_d;
	end

	assign busy           = (state_q != n2t_pkg::ST_IDLE) || strobe_q;
	assign char_strobe    = strobe_q;
	assign char_code      = code_q;
	assign last_char      = last_q;
	assign roman_overflow = ovf_q;

	`N2T_ASSERT_IMPL(a_strobe_busy, char_strobe, busy)
	`N2T_ASSERT_NEXT(a_last_ends, char_strobe && last_char, !char_strobe)
	`N2T_ASSERT_NEXT(a_accept_busy, accept, busy && !char_strobe)
	`N2T_ASSERT_IMPL(a_div_idle, drsp.done, state_q == n2t_pkg::ST_WAIT)

endmodule

FILE: tb/number_to_text_formatter_core_tb.sv
`timescale 1ns / 1ps

module number_to_text_formatter_core_tb;

	localparam int IdleLimit = 5000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] number_in;
	logic        char_strobe;
	logic [7:0]  char_code;
	logic        last_char;
	logic        roman_overflow;
	logic        cfg_we;
	logic        cfg_index;
	logic [5:0]  cfg_data;

	number_to_text_formatter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.number_in     (number_in),
		.char_strobe   (char_strobe),
		.char_code     (char_code),
		.last_char     (last_char),
		.roman_overflow(roman_overflow),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	typedef struct {
		logic [2:0]  fmt;
		logic [5:0]  pad;
		logic [31:0] value;
		string       txt;
		bit          ovf;
	} text_row_t;

	logic [7:0] pending_code[$];
	bit         pending_last[$];
	bit         pending_ovf[$];

	logic [2:0] cur_fmt;
	logic [5:0] cur_pad;
	int         errors;
	int         quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Builds the text of one number under the given format and padding.
	function automatic string render(input logic [31:0] raw, input logic [2:0] fmt,
		input logic [5:0] pad, output bit ovf);
		logic [31:0] mag;
		logic [31:0] scale;
		logic [31:0] d;
		string       s;
		string       digs;
		string       set;
		string       letters;
		bit          neg;
		neg = raw[31];
		mag = neg ? (32'd0 - raw) : raw;
		ovf = 1'b0;
		s = neg ? "-" : "";
		if (fmt == n2t_pkg::FMT_ROMAN_LO || fmt == n2t_pkg::FMT_ROMAN_UP) begin
			if (mag >= 32'd40000) begin
				ovf = 1'b1;
				s = $sformatf("%s%0d", s, mag);
			end else if (mag == 0) begin
				s = "0";
			end else begin
				set = (fmt == n2t_pkg::FMT_ROMAN_LO) ? "zwmdclxvi" : "ZWMDCLXVI";
				while (mag >= 32'd10000) begin
					s = {s, set.substr(0, 0)};
					mag = mag - 32'd10000;
				end
				scale = 32'd1000;
				for (int pos = 0; pos < 8; pos += 2) begin
					d = mag / scale;
					mag = mag - d * scale;
					if (d == 9)
						s = {s, set.substr(pos + 2, pos + 2), set.substr(pos, pos)};
					else if (d == 4)
						s = {s, set.substr(pos + 2, pos + 2), set.substr(pos + 1, pos + 1)};
					else begin
						if (d >= 5) begin
							s = {s, set.substr(pos + 1, pos + 1)};
							d = d - 5;
						end
						for (int k = 0; k < d; k++)
							s = {s, set.substr(pos + 2, pos + 2)};
					end
					scale = scale / 10;
				end
			end
		end else if (fmt == n2t_pkg::FMT_ALPHA_LO || fmt == n2t_pkg::FMT_ALPHA_UP) begin
			if (mag == 0) begin
				s = "0";
			end else begin
				letters = "";
				while (mag > 0) begin
					d = mag % 26;
					if (d == 0)
						d = 26;
					mag = (mag - d) / 26;
					letters = $sformatf("%c%s",
						((fmt == n2t_pkg::FMT_ALPHA_LO) ? 8'h61 : 8'h41) + d[7:0] - 8'd1,
						letters);
				end
				s = {s, letters};
			end
		end else begin
			// Unused format codes fall back to decimal as well.
			digs = $sformatf("%0d", mag);
			for (int i = digs.len(); i < pad; i++)
				s = {s, "0"};
			s = {s, digs};
		end
		return s;
	endfunction

	task automatic queue_text(input string s, input bit ovf);
		for (int i = 0; i < s.len(); i++) begin
			pending_code.push_back(s[i]);
			pending_last.push_back(i == s.len() - 1);
			pending_ovf.push_back(ovf);
		end
	endtask

	// Offers one item and returns at the edge that accepts it or, if a gap is drawn, after the gap.
	task automatic send_number(input logic [31:0] value, input string txt, input bit ovf);
		string s;
		bit    p_ovf;
		int    gap;
		start <= 1'b1;
		number_in <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		quiet_cycles = 0;
		if (txt.len() > 0)
			queue_text(txt, ovf);
		else begin
			s = render(value, cur_fmt, cur_pad, p_ovf);
			queue_text(s, p_ovf);
		end
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		else if ($urandom_range(0, 15) == 0)
			gap = $urandom_range(20, 150);
		else
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending_code.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_format(input logic [2:0] fmt, input logic [5:0] pad);
		cfg_we <= 1'b1;
		cfg_index <= n2t_pkg::CFG_FORMAT;
		cfg_data <= {3'd0, fmt};
		@(posedge clk);
		cfg_index <= n2t_pkg::CFG_PAD;
		cfg_data <= pad;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_fmt = fmt;
		cur_pad = pad;
	endtask

	function automatic logic [31:0] pick_value(input logic [2:0] fmt);
		int unsigned r;
		r = $urandom_range(0, 9);
		if ((fmt == n2t_pkg::FMT_ROMAN_LO || fmt == n2t_pkg::FMT_ROMAN_UP) && r < 7)
			return 32'($signed($urandom_range(0, 80000)) - 40000);
		if (r < 4)
			return $urandom;
		if (r < 7)
			return 32'($signed($urandom_range(0, 2000)) - 1000);
		if (r == 7)
			return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
				: 32'h7FFF_FFFF - $urandom_range(0, 3);
		return 32'($signed($urandom_range(0, 200)) - 100) * 26;
	endfunction

	always @(posedge clk) begin
		if (arst_n && char_strobe) begin
			quiet_cycles <= 0;
			if (pending_code.size() == 0) begin
				$error("unexpected char_code %h", char_code);
				errors++;
			end else begin
				if (char_code !== pending_code[0]) begin
					$error("char_code: expected %h, got %h", pending_code[0], char_code);
					errors++;
				end
				if (last_char !== pending_last[0]) begin
					$error("last_char: expected %b, got %b", pending_last[0], last_char);
					errors++;
				end
				if (roman_overflow !== pending_ovf[0]) begin
					$error("roman_overflow: expected %b, got %b", pending_ovf[0],
						roman_overflow);
					errors++;
				end
				void'(pending_code.pop_front());
				void'(pending_last.pop_front());
				void'(pending_ovf.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= IdleLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		text_row_t rows[$];
		logic [2:0] fmt;
		logic [5:0] pad;
		int unsigned sel;
		arst_n = 1'b0;
		start = 1'b0;
		number_in = 32'd0;
		cfg_we = 1'b0;
		cfg_index = n2t_pkg::CFG_FORMAT;
		cfg_data = 6'd0;
		cur_fmt = n2t_pkg::FMT_DEC;
		cur_pad = 6'd0;
		errors = 0;
		quiet_cycles = 0;
		rows = '{
			'{n2t_pkg::FMT_DEC, 6'd0, 32'd0, "0", 1'b0},
			'{n2t_pkg::FMT_DEC, 6'd0, 32'h8000_0000, "-2147483648", 1'b0},
			'{n2t_pkg::FMT_DEC, 6'd0, 32'h7FFF_FFFF, "2147483647", 1'b0},
			'{n2t_pkg::FMT_DEC, 6'd3, 32'hFFFF_FFFB, "-005", 1'b0},
			'{n2t_pkg::FMT_DEC, 6'd63, 32'd0, "", 1'b0},
			'{n2t_pkg::FMT_DEC, 6'd63, 32'h8000_0000, "", 1'b0},
			'{n2t_pkg::FMT_ROMAN_LO, 6'd0, 32'd0, "0", 1'b0},
			'{n2t_pkg::FMT_ROMAN_LO, 6'd0, 32'd4, "iv", 1'b0},
			'{n2t_pkg::FMT_ROMAN_LO, 6'd0, 32'hFFFF_FFF7, "-ix", 1'b0},
			'{n2t_pkg::FMT_ROMAN_LO, 6'd0, 32'd40000, "40000", 1'b1},
			'{n2t_pkg::FMT_ROMAN_LO, 6'd0, 32'h8000_0000, "-2147483648", 1'b1},
			'{n2t_pkg::FMT_ROMAN_UP, 6'd7, 32'd1994, "MCMXCIV", 1'b0},
			'{n2t_pkg::FMT_ROMAN_UP, 6'd7, 32'd39999, "", 1'b0},
			'{n2t_pkg::FMT_ROMAN_UP, 6'd7, 32'hFFFF_63C0, "-40000", 1'b1},
			'{n2t_pkg::FMT_ROMAN_UP, 6'd7, 32'd15555, "", 1'b0},
			'{n2t_pkg::FMT_ALPHA_LO, 6'd0, 32'd1, "a", 1'b0},
			'{n2t_pkg::FMT_ALPHA_LO, 6'd0, 32'd26, "z", 1'b0},
			'{n2t_pkg::FMT_ALPHA_LO, 6'd0, 32'd27, "aa", 1'b0},
			'{n2t_pkg::FMT_ALPHA_LO, 6'd0, 32'd702, "", 1'b0},
			'{n2t_pkg::FMT_ALPHA_UP, 6'd0, 32'd0, "0", 1'b0},
			'{n2t_pkg::FMT_ALPHA_UP, 6'd0, 32'hFFFF_FFE4, "-AB", 1'b0},
			'{n2t_pkg::FMT_ALPHA_UP, 6'd0, 32'h7FFF_FFFF, "", 1'b0},
			'{n2t_pkg::FMT_ALPHA_UP, 6'd0, 32'h8000_0000, "", 1'b0},
			'{3'd7, 6'd5, 32'd42, "00042", 1'b0},
			'{3'd5, 6'd0, 32'hFFFF_FFFF, "-1", 1'b0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first rows run on the reset settings, so no write comes before them.
		foreach (rows[i]) begin
			if (rows[i].fmt !== cur_fmt || rows[i].pad !== cur_pad) begin
				drain();
				set_format(rows[i].fmt, rows[i].pad);
			end
			send_number(rows[i].value, rows[i].txt, rows[i].ovf);
		end

		for (int phase = 0; phase < 7; phase++) begin
			drain();
			sel = $urandom_range(0, 9);
			fmt = (sel < 8) ? 3'(phase % 5) : 3'($urandom_range(5, 7));
			sel = $urandom_range(0, 5);
			pad = (sel == 0) ? 6'd63 : (sel == 1) ? 6'd0 : 6'($urandom_range(0, 63));
			set_format(fmt, pad);
			for (int n = 0; n < 20; n++)
				send_number(pick_value(fmt), "", 1'b0);
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_code.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
